// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the priority queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted (active low).
`define PIPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pipq assertion failed");
// Clocked check that also holds during reset.
`define PIPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("pipq assertion failed");
`else
`define PIPQ_ASSERT(lbl, clk, rst_n, prop)
`define PIPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/pipq_pkg.sv
// Package: sizes, codes and shared types of the pending interrupt priority queue.
`timescale 1ns / 1ps
`default_nettype none
package pipq_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_OUT_W = 6;
    localparam int VEC_W       = 8;
    localparam int LVL_W       = 4;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_RAISE   = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_SERVICE = 2'd2
    } t_op;

    typedef struct packed {
        logic [VEC_W-1:0] vector;
        logic [LVL_W-1:0] level;
    } t_entry;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             cmp;       // latch vector match flag
        logic             raise_ins; // apply an accepted raise
        logic             rm_shift;  // apply a remove that hit
        logic [VEC_W-1:0] vector;
        logic [LVL_W-1:0] level;
    } t_cell_cmd;

endpackage
`default_nettype wire

// File: rtl/core/pipq_if.sv
// Handshake interfaces: request, result and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none
interface pipq_in_if;
    import pipq_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [VEC_W-1:0] vector;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] cpu_mask;
    modport source (output valid, operation, vector, level, cpu_mask, input ready);
    modport sink   (input valid, operation, vector, level, cpu_mask, output ready);
endinterface

interface pipq_out_if;
    import pipq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   taken;
    logic [VEC_W-1:0]       taken_vector;
    logic [LVL_W-1:0]       new_mask;
    logic                   dropped;
    logic                   removed;
    logic [COUNT_OUT_W-1:0] pending_count;
    modport source (output valid, taken, taken_vector, new_mask, dropped, removed,
                    pending_count, input ready);
    modport sink   (input valid, taken, taken_vector, new_mask, dropped, removed,
                    pending_count, output ready);
endinterface

interface pipq_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pipq_cell.sv
// One table cell: holds an entry, compares it, and shifts to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module pipq_cell (
    input  wire                  i_clk,
    input  pipq_pkg::t_cell_cmd  i_cmd,
    input  wire                  i_occ,
    input  wire                  i_at_count,
    input  pipq_pkg::t_entry     i_prev_entry,
    input  wire                  i_prev_gt,
    input  pipq_pkg::t_entry     i_next_entry,
    input  wire                  i_pfx_in,
    output pipq_pkg::t_entry     o_entry,
    output logic                 o_gt,
    output logic                 o_match,
    output logic                 o_pfx_out
);
    import pipq_pkg::*;

    t_entry r_entry, n_entry;
    logic   r_match;

    assign o_entry   = r_entry;
    assign o_gt      = i_occ && (r_entry.level > i_cmd.level);
    assign o_match   = r_match;
    assign o_pfx_out = i_pfx_in | r_match;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.raise_ins && (o_gt || i_at_count)) begin
            // lowest shifted cell takes the new request
            n_entry = i_prev_gt ? i_prev_entry : t_entry'{i_cmd.vector, i_cmd.level};
        end else if (i_cmd.rm_shift && i_occ && o_pfx_out) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmd.cmp) begin
            r_match <= i_occ && (r_entry.vector == i_cmd.vector);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/pending_interrupt_priority_queue_core.sv
// Top level: pending interrupt priority queue built from a chain of table cells.
//
//  channel  | dir | handshake        | transaction
//  ---------+-----+------------------+---------------------------------------------
//  i_in     | in  | valid/ready      | operation, vector, level, cpu_mask
//  o_out    | out | valid/ready      | taken, taken_vector, new_mask, dropped, ...
//  i_cfg    | in  | valid/ready      | raise_enable (ready whenever out of reset)
//
//  For each transaction, every cell registers its vector match flag on
//  acceptance; in the execute state the match flags are reduced and the
//  cell chain shifts in one step. A new request is accepted the cycle after.
//  A full output register stalls the execute cycle until o_out.ready.
//  Reset (synchronous, active low) empties the table and sets raise_enable;
//  both channels hold ready low while reset is asserted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pending_interrupt_priority_queue_core (
    input wire            i_clk,
    input wire            i_rst_n,
    pipq_in_if.sink       i_in,
    pipq_out_if.source    o_out,
    pipq_cfg_if.sink      i_cfg
);
    import pipq_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_raise_enable;
    logic [OP_W-1:0]  r_op;
    logic [VEC_W-1:0] r_vec;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] r_mask;

    logic                   r_out_valid;
    logic                   r_out_taken;
    logic [VEC_W-1:0]       r_out_tvec;
    logic [LVL_W-1:0]       r_out_mask;
    logic                   r_out_dropped;
    logic                   r_out_removed;
    logic [COUNT_OUT_W-1:0] r_out_count;

    t_cell_cmd            w_cmd;
    t_entry               w_entry  [TABLE_DEPTH];
    t_entry               w_prev_e [TABLE_DEPTH];
    t_entry               w_next_e [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_gt, w_prev_gt, w_match, w_occ, w_at_count, w_is_top;
    logic [TABLE_DEPTH:0]   w_pfx;

    logic   accept, out_free, exec_fire, hit, raise_ok, top_gt, pop_fire;
    t_entry top_entry;

    // Request and configuration handshakes
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = i_rst_n;

    assign out_free  = !r_out_valid || o_out.ready;
    assign exec_fire = (r_state == S_EXEC) && out_free;

    // Match flags are registered at acceptance, so the vector comes straight
    // from the port in IDLE; the level compare is only used while executing.
    assign hit      = |w_match;
    assign raise_ok = r_raise_enable && !hit && (r_count < CNT_W'(TABLE_DEPTH));

    always_comb begin
        w_cmd           = '0;
        w_cmd.cmp       = accept;
        w_cmd.vector    = (r_state == S_IDLE) ? i_in.vector : r_vec;
        w_cmd.level     = r_lvl;
        w_cmd.raise_ins = exec_fire && (t_op'(r_op) == OP_RAISE) && raise_ok;
        w_cmd.rm_shift  = exec_fire && (t_op'(r_op) == OP_REMOVE) && hit;
    end

    // Cell chain: cell 0 holds the lowest level, the entry at count-1 is the top.
    assign w_pfx[0] = 1'b0;
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        assign w_occ[k]      = CNT_W'(k) < r_count;
        assign w_at_count[k] = r_count == CNT_W'(k);
        assign w_is_top[k]   = r_count == CNT_W'(k + 1);
        if (k == 0) begin : g_first
            assign w_prev_e[k]  = w_entry[k];
            assign w_prev_gt[k] = 1'b0;
        end else begin : g_mid
            assign w_prev_e[k]  = w_entry[k-1];
            assign w_prev_gt[k] = w_gt[k-1];
        end
        if (k == TABLE_DEPTH - 1) begin : g_last
            assign w_next_e[k] = w_entry[k];
        end else begin : g_inner
            assign w_next_e[k] = w_entry[k+1];
        end

        pipq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_occ        (w_occ[k]),
            .i_at_count   (w_at_count[k]),
            .i_prev_entry (w_prev_e[k]),
            .i_prev_gt    (w_prev_gt[k]),
            .i_next_entry (w_next_e[k]),
            .i_pfx_in     (w_pfx[k]),
            .o_entry      (w_entry[k]),
            .o_gt         (w_gt[k]),
            .o_match      (w_match[k]),
            .o_pfx_out    (w_pfx[k+1])
        );
    end

    // Top entry select: one-hot AND-OR over the cells
    always_comb begin
        top_entry = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (w_is_top[k]) begin
                top_entry = top_entry | w_entry[k];
            end
        end
    end
    assign top_gt   = (r_count != '0) && (top_entry.level > r_mask);
    // service that pops the top entry in this execute cycle
    assign pop_fire = exec_fire && (t_op'(r_op) == OP_SERVICE) && top_gt;

    always_comb begin
        n_count = r_count;
        unique case (t_op'(r_op))
            OP_RAISE:   if (raise_ok) n_count = r_count + CNT_W'(1);
            OP_REMOVE:  if (hit)      n_count = r_count - CNT_W'(1);
            OP_SERVICE: if (top_gt)   n_count = r_count - CNT_W'(1);
            default:    n_count = r_count;
        endcase
    end

    // State, count and result register (result payload needs no reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_raise_enable <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_raise_enable <= i_cfg.data;
            end
            // result drained; a fresh result in the same cycle keeps valid high
            if (o_out.ready && !exec_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state       <= S_IDLE;
                        r_count       <= n_count;
                        r_out_valid   <= 1'b1;
                        r_out_taken   <= pop_fire;
                        r_out_tvec    <= pop_fire ? top_entry.vector : '0;
                        r_out_mask    <= pop_fire ? top_entry.level : r_mask;
                        r_out_dropped <= (t_op'(r_op) == OP_RAISE) && !raise_ok;
                        r_out_removed <= (t_op'(r_op) == OP_REMOVE) && hit;
                        r_out_count   <= COUNT_OUT_W'(n_count);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Request capture (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in.operation;
            r_vec  <= i_in.vector;
            r_lvl  <= i_in.level;
            r_mask <= i_in.cpu_mask;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.taken         = r_out_taken;
    assign o_out.taken_vector  = r_out_tvec;
    assign o_out.new_mask      = r_out_mask;
    assign o_out.dropped       = r_out_dropped;
    assign o_out.removed       = r_out_removed;
    assign o_out.pending_count = r_out_count;

    // Checks
    `PIPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_DEPTH))
    `PIPQ_ASSERT(a_accept_exec, i_clk, i_rst_n, accept |=> (r_state == S_EXEC))
    `PIPQ_ASSERT(a_pop_count, i_clk, i_rst_n, pop_fire |=> (r_count == $past(r_count) - CNT_W'(1)))
    `PIPQ_ASSERT(a_flags_excl, i_clk, i_rst_n, r_out_valid |-> !(r_out_dropped && r_out_removed))

endmodule
`default_nettype wire
